FILE: sv/adpl_pkg.sv
// Shared types, widths, register codes and reset values of the position limiter.
`default_nettype none

package adpl_pkg;

    // Data path widths.
    localparam int DIVIDEND_W = 64;
    localparam int DIVISOR_W  = 33;
    localparam int MUL_W      = 32;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_MAX_ACCEL      = 3'd0;
    localparam logic [2:0] REG_MAX_DECEL      = 3'd1;
    localparam logic [2:0] REG_ARRIVAL_WINDOW = 3'd2;
    localparam logic [2:0] REG_MAX_SPEED      = 3'd3;
    localparam logic [2:0] REG_REGULATOR_GAIN = 3'd4;

    // Reset values, Q16.16.
    localparam logic [30:0] RST_MAX_ACCEL      = 31'd65536;
    localparam logic [31:0] RST_MAX_DECEL      = 32'hFFFF_0000;
    localparam logic [30:0] RST_ARRIVAL_WINDOW = 31'd65536;
    localparam logic [30:0] RST_MAX_SPEED      = 31'd65536;
    localparam logic [30:0] RST_REGULATOR_GAIN = 31'd65536;

    // Limits.
    localparam logic [33:0] STEP_LIMIT = 34'h2_0000_0000;
    localparam logic [31:0] S32_MAX    = 32'h7FFF_FFFF;
    localparam logic [31:0] S32_MIN    = 32'h8000_0000;

    // Status of the shared divider.
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

`default_nettype wire

FILE: sv/adpl_mul.sv
// Shared unsigned multiplier with a registered product.
`default_nettype none

module adpl_mul #(
    parameter int A_W = adpl_pkg::MUL_W,
    parameter int B_W = adpl_pkg::MUL_W
) (
    input  wire logic               clk,
    input  wire logic               en,
    input  wire logic [A_W-1:0]     a,
    input  wire logic [B_W-1:0]     b,
    output logic      [A_W+B_W-1:0] prod
);

    logic [A_W+B_W-1:0] prod_reg;

    // The product register holds its value until the next enabled cycle.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= (A_W+B_W)'(a) * (A_W+B_W)'(b);
        end
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

FILE: sv/adpl_div.sv
// Shared restoring divider, one quotient bit per cycle.
`default_nettype none

module adpl_div #(
    parameter int DIVIDEND_W = adpl_pkg::DIVIDEND_W,
    parameter int DIVISOR_W  = adpl_pkg::DIVISOR_W
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [DIVIDEND_W-1:0] dividend,
    input  wire logic [DIVISOR_W-1:0]  divisor,
    output logic      [DIVIDEND_W-1:0] quotient,
    output adpl_pkg::div_stat_t        stat
);

    import adpl_pkg::*;

    localparam int CNT_W = $clog2(DIVIDEND_W);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [DIVISOR_W-1:0]  den_reg, den_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W:0]    shifted;
    logic                  fits;

    // One restoring step: shift in the next dividend bit and try to subtract.
    always_comb
    begin
        shifted   = {rem_reg, quo_reg[DIVIDEND_W-1]};
        fits      = shifted >= {1'b0, den_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIVIDEND_W - 1);
            den_next  = divisor;
            rem_next  = '0;
            quo_next  = dividend;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? DIVISOR_W'(shifted - {1'b0, den_reg}) : shifted[DIVISOR_W-1:0];
            quo_next = {quo_reg[DIVIDEND_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

`default_nettype wire

FILE: sv/accel_decel_position_limiter.sv
// The arrival window path does not use the divider; the braking path makes two and the
// accelerating path three 64-step passes through the shared divider.
// Throughput: one transaction at a time; item_ready is high only while the sequencer is idle.
// A finished result waits in the output register while the next transaction is accepted.
// Reset: the speed setpoint clears to zero and the registers return to 1.0 and -1.0 (Q16.16).
// Top level: configuration registers, sequencer and shared multiplier and divider.
`default_nettype none

module accel_decel_position_limiter (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Configuration port.
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // Input channel.
    input  wire logic        item_valid,
    output logic             item_ready,
    input  wire logic [31:0] target_position,
    input  wire logic [31:0] measured_position,
    input  wire logic [31:0] measured_speed,
    input  wire logic [30:0] tick_period,
    // Result channel.
    output logic             result_valid,
    input  wire logic        result_ready,
    output logic      [31:0] limited_position
);

    import adpl_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_PREP, S_CHK, S_SQ, S_DSTOP, S_DCAP, S_MACC, S_DINC,
        S_MDEC, S_DDEC, S_ACC, S_CAP, S_DEC, S_CLAMP, S_OUT
    } state_t;

    // Saturate a 36-bit signed value to the signed 32-bit range.
    function automatic logic [31:0] sat32(input logic [35:0] v);
        logic signed [35:0] sv;
        sv = $signed(v);
        if (sv > $signed({4'b0000, S32_MAX}))
        begin
            return S32_MAX;
        end
        else if (sv < $signed({4'b1111, S32_MIN}))
        begin
            return S32_MIN;
        end
        return v[31:0];
    endfunction

    state_t state_reg, state_next;

    logic [30:0] max_accel_reg, arrival_window_reg, max_speed_reg, regulator_gain_reg;
    logic [31:0] max_decel_reg;

    logic [31:0] tgt_reg, tgt_next;
    logic [31:0] meas_reg, meas_next;
    logic [31:0] spd_reg, spd_next;
    logic [30:0] dt_reg, dt_next;
    logic [32:0] eabs_reg, eabs_next;
    logic        back_reg, back_next;
    logic [31:0] sabs_reg, sabs_next;
    logic [46:0] cap_reg, cap_next;
    logic [33:0] step_reg, step_next;
    logic [31:0] sp_reg, sp_next;
    logic [31:0] out_pos_reg, out_pos_next;
    logic        out_valid_reg, out_valid_next;

    logic [32:0] err;
    logic [31:0] dmag;
    logic [30:0] gain_eff;
    logic        sp_pos;
    logic [35:0] sum;
    logic        load_out;
    logic        cfg_wr;

    logic                  mul_en;
    logic [MUL_W-1:0]      mul_a, mul_b;
    logic [2*MUL_W-1:0]    mul_prod;
    logic                  div_start;
    logic [DIVIDEND_W-1:0] div_dividend, div_quot;
    logic [DIVISOR_W-1:0]  div_divisor;
    div_stat_t             div_stat;

    adpl_mul #(
        .A_W (MUL_W),
        .B_W (MUL_W)
    ) u_mul (
        .clk  (clk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (mul_prod)
    );

    adpl_div #(
        .DIVIDEND_W (DIVIDEND_W),
        .DIVISOR_W  (DIVISOR_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quot),
        .stat     (div_stat)
    );

    // Configuration writes and read-back.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        case (paddr[4:2])
            REG_MAX_ACCEL:      prdata = {1'b0, max_accel_reg};
            REG_MAX_DECEL:      prdata = max_decel_reg;
            REG_ARRIVAL_WINDOW: prdata = {1'b0, arrival_window_reg};
            REG_MAX_SPEED:      prdata = {1'b0, max_speed_reg};
            REG_REGULATOR_GAIN: prdata = {1'b0, regulator_gain_reg};
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_accel_reg      <= RST_MAX_ACCEL;
            max_decel_reg      <= RST_MAX_DECEL;
            arrival_window_reg <= RST_ARRIVAL_WINDOW;
            max_speed_reg      <= RST_MAX_SPEED;
            regulator_gain_reg <= RST_REGULATOR_GAIN;
        end
        else if (cfg_wr)
        begin
            case (paddr[4:2])
                REG_MAX_ACCEL:      max_accel_reg      <= pwdata[30:0];
                REG_MAX_DECEL:      max_decel_reg      <= pwdata;
                REG_ARRIVAL_WINDOW: arrival_window_reg <= pwdata[30:0];
                REG_MAX_SPEED:      max_speed_reg      <= pwdata[30:0];
                REG_REGULATOR_GAIN: regulator_gain_reg <= pwdata[30:0];
                default:            ;
            endcase
        end
    end

    // Deceleration magnitude and gain, with one LSB standing in for invalid values.
    assign dmag     = max_decel_reg[31] ? (~max_decel_reg + 32'd1) : 32'd1;
    assign gain_eff = (regulator_gain_reg == '0) ? 31'd1 : regulator_gain_reg;

    assign err    = {tgt_reg[31], tgt_reg} - {meas_reg[31], meas_reg};
    assign sp_pos = !sp_reg[31] && (sp_reg != '0);

    assign item_ready       = (state_reg == S_IDLE);
    assign result_valid     = out_valid_reg;
    assign limited_position = out_pos_reg;

    // Sequencer: steers the shared multiplier and divider and updates the setpoint.
    always_comb
    begin
        state_next     = state_reg;
        tgt_next       = tgt_reg;
        meas_next      = meas_reg;
        spd_next       = spd_reg;
        dt_next        = dt_reg;
        eabs_next      = eabs_reg;
        back_next      = back_reg;
        sabs_next      = sabs_reg;
        cap_next       = cap_reg;
        step_next      = step_reg;
        sp_next        = sp_reg;
        out_pos_next   = out_pos_reg;
        out_valid_next = out_valid_reg && !result_ready;
        load_out       = 1'b0;
        sum            = '0;
        mul_en         = 1'b0;
        mul_a          = sabs_reg;
        mul_b          = sabs_reg;
        div_start      = 1'b0;
        div_dividend   = mul_prod;
        div_divisor    = {1'b0, 1'b0, gain_eff};

        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    tgt_next   = target_position;
                    meas_next  = measured_position;
                    spd_next   = measured_speed;
                    dt_next    = tick_period;
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                back_next  = err[32];
                eabs_next  = err[32] ? (~err + 33'd1) : err;
                sabs_next  = spd_reg[31] ? (~spd_reg + 32'd1) : spd_reg;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (eabs_reg < {2'b00, arrival_window_reg})
                begin
                    sp_next    = (eabs_reg[32:31] != 2'b00) ? S32_MAX : eabs_reg[31:0];
                    state_next = S_CLAMP;
                end
                else
                begin
                    mul_en     = 1'b1;
                    state_next = S_SQ;
                end
            end
            S_SQ:
            begin
                // Stopping distance: speed squared over twice the deceleration.
                div_start   = 1'b1;
                div_divisor = {dmag, 1'b0};
                state_next  = S_DSTOP;
            end
            S_DSTOP:
            begin
                if (div_stat.done)
                begin
                    if ({31'd0, eabs_reg} > div_quot)
                    begin
                        div_start    = 1'b1;
                        div_dividend = {17'd0, max_speed_reg, 16'd0};
                        state_next   = S_DCAP;
                    end
                    else
                    begin
                        mul_en     = 1'b1;
                        mul_a      = dmag;
                        mul_b      = {1'b0, dt_reg};
                        state_next = S_MDEC;
                    end
                end
            end
            S_DCAP:
            begin
                if (div_stat.done)
                begin
                    cap_next   = div_quot[46:0];
                    mul_en     = 1'b1;
                    mul_a      = {1'b0, max_accel_reg};
                    mul_b      = {1'b0, dt_reg};
                    state_next = S_MACC;
                end
            end
            S_MACC:
            begin
                div_start  = 1'b1;
                state_next = S_DINC;
            end
            S_DINC:
            begin
                if (div_stat.done)
                begin
                    step_next  = (div_quot > DIVIDEND_W'(STEP_LIMIT)) ? STEP_LIMIT
                                                                       : div_quot[33:0];
                    state_next = S_ACC;
                end
            end
            S_MDEC:
            begin
                div_start  = 1'b1;
                state_next = S_DDEC;
            end
            S_DDEC:
            begin
                if (div_stat.done)
                begin
                    step_next  = (div_quot > DIVIDEND_W'(STEP_LIMIT)) ? STEP_LIMIT
                                                                       : div_quot[33:0];
                    state_next = S_DEC;
                end
            end
            S_ACC:
            begin
                sum        = {{4{sp_reg[31]}}, sp_reg} + {2'b00, step_reg};
                sp_next    = sat32(sum);
                state_next = S_CAP;
            end
            S_CAP:
            begin
                // Cap the accelerated setpoint at the scaled top speed.
                if (sp_pos && ({16'd0, sp_reg[30:0]} > cap_reg))
                begin
                    sp_next = {1'b0, cap_reg[30:0]};
                end
                state_next = S_CLAMP;
            end
            S_DEC:
            begin
                sum        = {{4{sp_reg[31]}}, sp_reg} - {2'b00, step_reg};
                sp_next    = sat32(sum);
                state_next = S_CLAMP;
            end
            S_CLAMP:
            begin
                if (sp_pos && ({2'b00, sp_reg[30:0]} > eabs_reg))
                begin
                    sp_next = eabs_reg[31:0];
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                // Wait for room in the output register, then hand the result over.
                if (!out_valid_reg || result_ready)
                begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
                if (back_reg)
                begin
                    sum = {{4{meas_reg[31]}}, meas_reg} - {{4{sp_reg[31]}}, sp_reg};
                end
                else
                begin
                    sum = {{4{meas_reg[31]}}, meas_reg} + {{4{sp_reg[31]}}, sp_reg};
                end
                if (load_out)
                begin
                    out_pos_next   = sat32(sum);
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state and the persistent speed setpoint.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sp_reg        <= sp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working registers of the current transaction.
    always_ff @(posedge clk)
    begin
        tgt_reg     <= tgt_next;
        meas_reg    <= meas_next;
        spd_reg     <= spd_next;
        dt_reg      <= dt_next;
        eabs_reg    <= eabs_next;
        back_reg    <= back_next;
        sabs_reg    <= sabs_next;
        cap_reg     <= cap_next;
        step_reg    <= step_next;
        out_pos_reg <= out_pos_next;
    end

endmodule

`default_nettype wire

FILE: sv/adpl_checker.sv
// Port-level assertions for the position limiter and the bind that attaches them.
`default_nettype none

module adpl_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        item_valid,
    input wire logic        item_ready,
    input wire logic        result_valid,
    input wire logic        result_ready,
    input wire logic [31:0] limited_position
);

    // A result that is not taken stays valid and unchanged.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(limited_position))
        else $error("result changed or dropped while stalled");

    // The block works on one transaction at a time.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("input accepted while a transaction is in progress");

    // No result can appear in the cycle right after an accept.
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && !result_valid |=> !result_valid)
        else $error("result appeared too early");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge clk) !rst_n |=> !result_valid)
        else $error("result valid after reset");

endmodule

bind accel_decel_position_limiter adpl_checker u_adpl_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .item_valid       (item_valid),
    .item_ready       (item_ready),
    .result_valid     (result_valid),
    .result_ready     (result_ready),
    .limited_position (limited_position)
);

`default_nettype wire

FILE: bench/accel_decel_position_limiter_test.sv
// Self-checking testbench for the acceleration and deceleration position limiter.
`default_nettype none

module accel_decel_position_limiter_test;

    timeunit 1ns;
    timeprecision 1ps;

    import adpl_pkg::*;

    localparam int BLOCKS_PER_PHASE = 6;
    localparam int ITEMS_PER_BLOCK  = 100;
    localparam int WATCHDOG_LIMIT   = 3000;
    localparam int END_SETTLE       = 250;
    localparam int MAX_PRINTS       = 40;

    // Clock, reset and block ports.
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        item_valid = 1'b0;
    logic        item_ready;
    logic [31:0] target_position = '0;
    logic [31:0] measured_position = '0;
    logic [31:0] measured_speed = '0;
    logic [30:0] tick_period = '0;
    logic        result_valid;
    logic        result_ready = 1'b0;
    logic [31:0] limited_position;

    // Register copies and speed setpoint of the prediction.
    logic [30:0] cfg_max_accel      = RST_MAX_ACCEL;
    logic [31:0] cfg_max_decel      = RST_MAX_DECEL;
    logic [30:0] cfg_arrival_window = RST_ARRIVAL_WINDOW;
    logic [30:0] cfg_max_speed      = RST_MAX_SPEED;
    logic [30:0] cfg_regulator_gain = RST_REGULATOR_GAIN;
    longint      model_setpoint = 0;

    // Predicted positions waiting for their result transactions.
    logic [31:0] expected_positions[$];
    logic [31:0] predicted_pos;
    logic [31:0] last_limited = '0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int fail_count = 0;
    int items_sent = 0;
    int results_seen = 0;
    int writes_done = 0;
    int stall_cycles = 0;

    accel_decel_position_limiter dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .item_valid        (item_valid),
        .item_ready        (item_ready),
        .target_position   (target_position),
        .measured_position (measured_position),
        .measured_speed    (measured_speed),
        .tick_period       (tick_period),
        .result_valid      (result_valid),
        .result_ready      (result_ready),
        .limited_position  (limited_position)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Prints one mismatch line and counts it.
    task automatic report_mismatch(input string msg);
        fail_count++;
        if (fail_count <= MAX_PRINTS)
        begin
            $display("mismatch at %0t: %s", $realtime, msg);
        end
    endtask

    function automatic longint clamp_s32(input longint v);
        if (v > 64'sd2147483647)
        begin
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // Computes the limited position of one tick and advances the speed setpoint.
    function automatic logic [31:0] predict_limited(input logic [31:0] tgt,
                                                    input logic [31:0] meas,
                                                    input logic [31:0] spd,
                                                    input logic [30:0] dt);
        longint          t, m, s, err, sp, o, decel;
        longint unsigned dmag, gain, sabs, stop, eabs, cap, inc, dec;
        bit              back;
        t = longint'($signed(tgt));
        m = longint'($signed(meas));
        s = longint'($signed(spd));
        decel = longint'($signed(cfg_max_decel));
        // A deceleration that is not negative counts as one LSB, as does a zero gain.
        dmag = (decel < 0) ? $unsigned(-decel) : 64'd1;
        gain = (cfg_regulator_gain != 0) ? 64'(cfg_regulator_gain) : 64'd1;
        sabs = (s < 0) ? $unsigned(-s) : $unsigned(s);
        stop = (sabs * sabs) / (64'd2 * dmag);
        err = t - m;
        back = (err < 0);
        eabs = back ? $unsigned(-err) : $unsigned(err);
        sp = model_setpoint;
        if (eabs < 64'(cfg_arrival_window))
        begin
            sp = (eabs > 64'd2147483647) ? 64'sd2147483647 : $signed(eabs);
        end
        else if (eabs > stop)
        begin
            cap = (64'(cfg_max_speed) << 16) / gain;
            inc = (64'(cfg_max_accel) * 64'(dt)) / gain;
            if (inc > 64'(STEP_LIMIT))
            begin
                inc = 64'(STEP_LIMIT);
            end
            sp = clamp_s32(sp + $signed(inc));
            if (sp > 0 && $unsigned(sp) > cap)
            begin
                sp = $signed(cap);
            end
        end
        else
        begin
            dec = (dmag * 64'(dt)) / gain;
            if (dec > 64'(STEP_LIMIT))
            begin
                dec = 64'(STEP_LIMIT);
            end
            sp = clamp_s32(sp - $signed(dec));
        end
        // A positive setpoint never overshoots the remaining error.
        if (sp > 0 && $unsigned(sp) > eabs)
        begin
            sp = $signed(eabs);
        end
        model_setpoint = sp;
        o = clamp_s32(back ? (m - sp) : (m + sp));
        return o[31:0];
    endfunction

    // Sends one tick transaction and records its predicted result.
    task automatic send_item(input logic [31:0] tgt, input logic [31:0] meas,
                             input logic [31:0] spd, input logic [30:0] dt);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid        <= 1'b1;
        target_position   <= tgt;
        measured_position <= meas;
        measured_speed    <= spd;
        tick_period       <= dt;
        do
            @(posedge clk);
        while (!item_ready);
        last_limited = predict_limited(tgt, meas, spd, dt);
        expected_positions.push_back(last_limited);
        items_sent++;
    endtask

    // Stops sending and waits until every predicted result has arrived.
    task automatic drain_results;
        item_valid <= 1'b0;
        @(posedge clk);
        while (expected_positions.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Writes one register once the block is idle, then reads it back.
    task automatic cfg_write(input logic [2:0] idx, input logic [31:0] value);
        logic [31:0] want;
        drain_results();
        want = (idx == REG_MAX_DECEL) ? value : {1'b0, value[30:0]};
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        // Back-to-back read of the same register.
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== want)
        begin
            report_mismatch($sformatf("register %0d reads %h, written %h", idx, prdata, want));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_MAX_ACCEL:      cfg_max_accel = value[30:0];
            REG_MAX_DECEL:      cfg_max_decel = value;
            REG_ARRIVAL_WINDOW: cfg_arrival_window = value[30:0];
            REG_MAX_SPEED:      cfg_max_speed = value[30:0];
            REG_REGULATOR_GAIN: cfg_regulator_gain = value[30:0];
            default:            ;
        endcase
        writes_done++;
    endtask

    task automatic restore_reset_config;
        cfg_write(REG_MAX_ACCEL, {1'b0, RST_MAX_ACCEL});
        cfg_write(REG_MAX_DECEL, RST_MAX_DECEL);
        cfg_write(REG_ARRIVAL_WINDOW, {1'b0, RST_ARRIVAL_WINDOW});
        cfg_write(REG_MAX_SPEED, {1'b0, RST_MAX_SPEED});
        cfg_write(REG_REGULATOR_GAIN, {1'b0, RST_REGULATOR_GAIN});
    endtask

    // Random signed value whose magnitude spans many orders.
    function automatic logic [31:0] random_offset(input int min_shift);
        logic [31:0] mag;
        mag = $urandom() >> $urandom_range(31, min_shift);
        return ($urandom_range(1) != 0) ? (32'd0 - mag) : mag;
    endfunction

    // Arrival window: zero error, both directions, and the window at its extremes.
    task automatic test_arrival_window;
        send_item(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 31'h0000_4000);
        send_item(32'h0000_8000, 32'h0000_0000, 32'h0000_0000, 31'h0000_4000);
        send_item(32'h0000_0000, 32'h0000_C000, 32'hFFFF_0000, 31'h0000_4000);
        cfg_write(REG_ARRIVAL_WINDOW, 32'h7FFF_FFFF);
        send_item(32'h3FFF_FFFE, 32'hC000_0000, 32'h0000_0000, 31'h0000_4000);
        send_item(32'h3FFF_FFFF, 32'hC000_0000, 32'h0000_0000, 31'h0000_4000);
        cfg_write(REG_ARRIVAL_WINDOW, 32'h0000_0000);
        send_item(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 31'h0000_4000);
    endtask

    // Accelerating path, the speed cap and the step limit.
    task automatic test_accelerate_and_cap;
        restore_reset_config();
        send_item(32'h000A_0000, 32'h0000_0000, 32'h0000_0000, 31'h0000_4000);
        send_item(32'h000A_0000, 32'h0000_4000, 32'h0000_4000, 31'h0000_4000);
        send_item(32'h000A_0000, 32'h0000_0000, 32'h0000_0000, 31'h7FFF_FFFF);
        cfg_write(REG_MAX_ACCEL, 32'hFFFF_FFFF);
        cfg_write(REG_REGULATOR_GAIN, 32'h0000_0001);
        cfg_write(REG_MAX_SPEED, 32'h7FFF_FFFF);
        send_item(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 31'h7FFF_FFFF);
    endtask

    // Braking path in both directions, down to a negative setpoint.
    task automatic test_brake_and_negative_setpoint;
        restore_reset_config();
        send_item(32'h000A_0000, 32'h0000_0000, 32'h0008_0000, 31'h0000_4000);
        send_item(32'hFFF6_0000, 32'h0000_0000, 32'hFFF8_0000, 31'h0000_4000);
        send_item(32'h000A_0000, 32'h0000_0000, 32'h0008_0000, 31'h7FFF_FFFF);
        send_item(32'h000A_0000, 32'h0000_0000, 32'h8000_0000, 31'h7FFF_FFFF);
    endtask

    // A negative setpoint pushes the output past both ends of the range.
    task automatic test_output_saturation;
        send_item(32'h8000_0000, 32'h7FFF_FFF0, 32'h8000_0000, 31'h7FFF_FFFF);
        send_item(32'h7FFF_FFFF, 32'h8000_0010, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
    endtask

    // Deceleration that is zero or positive, extreme deceleration, zero and huge gain.
    task automatic test_decel_and_gain_corners;
        restore_reset_config();
        cfg_write(REG_MAX_DECEL, 32'h0000_0000);
        send_item(32'h0010_0000, 32'h0000_0000, 32'h0000_1000, 31'h0000_4000);
        cfg_write(REG_MAX_DECEL, 32'h0001_0000);
        send_item(32'h0010_0000, 32'h0000_0000, 32'h0010_0000, 31'h0001_0000);
        cfg_write(REG_MAX_DECEL, 32'h8000_0000);
        send_item(32'h0010_0000, 32'h0000_0000, 32'h7FFF_FFFF, 31'h0001_0000);
        cfg_write(REG_MAX_DECEL, 32'hFFFF_FFFF);
        cfg_write(REG_REGULATOR_GAIN, 32'h0000_0000);
        send_item(32'h0100_0000, 32'h0000_0000, 32'h0000_0000, 31'h0000_0100);
        cfg_write(REG_REGULATOR_GAIN, 32'h7FFF_FFFF);
        cfg_write(REG_MAX_ACCEL, 32'h0000_0001);
        send_item(32'h0100_0000, 32'h0000_0000, 32'h0000_0000, 31'h7FFF_FFFF);
        cfg_write(REG_MAX_SPEED, 32'h0000_0000);
        send_item(32'h0100_0000, 32'h0000_0000, 32'h0000_0000, 31'h0001_0000);
    endtask

    // Every input field at its extremes, including a zero tick period.
    task automatic test_field_extremes;
        restore_reset_config();
        send_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
        send_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h0000_0000);
        send_item(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 31'h0000_0000);
    endtask

    // Picks a register set: realistic, fully random, extremes or the reset values.
    task automatic load_random_config;
        int          kind;
        logic [31:0] v;
        kind = $urandom_range(9);
        if (kind < 5)
        begin
            cfg_write(REG_MAX_ACCEL, $urandom_range(1 << 22, 1 << 12));
            cfg_write(REG_MAX_DECEL, 32'd0 - $urandom_range(1 << 22, 1 << 12));
            cfg_write(REG_ARRIVAL_WINDOW, $urandom_range(1 << 16, 0));
            cfg_write(REG_MAX_SPEED, $urandom_range(1 << 24, 1 << 12));
            cfg_write(REG_REGULATOR_GAIN, $urandom_range(1 << 20, 1 << 12));
        end
        else if (kind < 7)
        begin
            v = $urandom();
            cfg_write(REG_MAX_ACCEL, (v[30:0] == 0) ? 32'd1 : v);
            cfg_write(REG_MAX_DECEL, 32'h8000_0000 | $urandom());
            cfg_write(REG_ARRIVAL_WINDOW, $urandom());
            cfg_write(REG_MAX_SPEED, $urandom());
            v = $urandom();
            cfg_write(REG_REGULATOR_GAIN, (v[30:0] == 0) ? 32'd1 : v);
        end
        else if (kind < 9)
        begin
            cfg_write(REG_MAX_ACCEL, $urandom_range(1) ? 32'h7FFF_FFFF : 32'd1);
            cfg_write(REG_MAX_DECEL, $urandom_range(1) ? 32'h8000_0000 : 32'hFFFF_FFFF);
            cfg_write(REG_ARRIVAL_WINDOW, $urandom_range(1) ? 32'h7FFF_FFFF : 32'd0);
            cfg_write(REG_MAX_SPEED, $urandom_range(1) ? 32'h7FFF_FFFF : 32'd0);
            cfg_write(REG_REGULATOR_GAIN, $urandom_range(1) ? 32'h7FFF_FFFF : 32'd1);
        end
        else
        begin
            restore_reset_config();
        end
    endtask

    // Mostly closed-loop approach sequences toward a target, mixed with noise ticks.
    task automatic test_random_traffic(input int sender_pct, input int receiver_pct);
        logic [31:0] tgt, traj_pos, spd;
        logic [30:0] base_dt, dt;
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
        for (int blk = 0; blk < BLOCKS_PER_PHASE; blk++)
        begin
            load_random_config();
            base_dt = ($urandom_range(9) == 0) ? 31'($urandom()) : 31'($urandom_range(4096, 1));
            traj_pos = random_offset(1);
            tgt = traj_pos + random_offset(6);
            for (int n = 0; n < ITEMS_PER_BLOCK; n++)
            begin
                if ($urandom_range(3) == 0)
                begin
                    send_item($urandom(), $urandom(), $urandom(), 31'($urandom()));
                end
                else
                begin
                    if ($urandom_range(24) == 0)
                    begin
                        tgt = traj_pos + random_offset(6);
                    end
                    spd = random_offset(8);
                    dt = ($urandom_range(49) == 0) ? 31'd0 : base_dt + 31'($urandom_range(15));
                    send_item(tgt, traj_pos + 32'($urandom_range(64)) - 32'd32, spd, dt);
                    traj_pos = last_limited;
                end
            end
        end
    endtask

    // Result side: random back-pressure, comparison and the stall watchdog.
    always @(posedge clk)
    begin
        result_ready <= ($urandom_range(99) >= recv_idle_pct);
        if (rst_n)
        begin
            if (result_valid && result_ready)
            begin
                results_seen++;
                if (expected_positions.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result %h", limited_position));
                end
                else
                begin
                    predicted_pos = expected_positions.pop_front();
                    if (limited_position !== predicted_pos)
                    begin
                        report_mismatch($sformatf("result %0d: limited_position %h, predicted %h",
                                                  results_seen, limited_position, predicted_pos));
                    end
                end
            end
            if ((item_valid && item_ready) || (result_valid && result_ready))
            begin
                stall_cycles = 0;
            end
            else
            begin
                stall_cycles++;
            end
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no transaction for %0d cycles", stall_cycles);
                $display("status: fail");
                $finish;
            end
        end
    end

    // Test sequence.
    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_idle_pct = 11;
        recv_idle_pct = 57;
        test_arrival_window();
        test_accelerate_and_cap();
        test_brake_and_negative_setpoint();
        test_output_saturation();
        test_decel_and_gain_corners();
        test_field_extremes();
        test_random_traffic(11, 57);
        test_random_traffic(57, 11);
        test_random_traffic(0, 0);
        drain_results();
        repeat (END_SETTLE) @(posedge clk);
        if (expected_positions.size() != 0)
        begin
            report_mismatch($sformatf("%0d predicted results never arrived",
                                      expected_positions.size()));
        end
        $display("covered %0d ticks, %0d results and %0d register writes with readback",
                 items_sent, results_seen, writes_done);
        $display("idle mixes sender/receiver 11/57, 57/11 and 0/0; %0d mismatches", fail_count);
        if (fail_count == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire
